>>> rtl/core/qte_pkg.sv
package qte_pkg;

	// widths of the internal datapath
	localparam int AW   = 34;  // numerators and denominators, Q2.30 scaled by two
	localparam int SW   = 32;  // saturated asin argument, Q1.30, must hold +1.0
	localparam int CW   = 52;  // cordic x / y lanes (value times 2^16 plus gain)
	localparam int ZW   = 21;  // cordic angle, radians * 2^16
	localparam int NCOR = 17;  // cordic iterations
	localparam int NSQ  = 31;  // result bits of the square root
	localparam int RW   = 62;  // square root remainder and partial root

	localparam logic signed [AW-1:0] ONE_Q30 = 34'sh0_4000_0000;
	localparam logic signed [AW-1:0] SAT_POS = 34'sh0_4000_0000;
	localparam logic signed [AW-1:0] SAT_NEG = -34'sh0_4000_0000;
	localparam logic [RW-1:0]        ONE_Q60 = 62'h1000_0000_0000_0000;

	localparam logic signed [ZW-1:0] ANG_PI = 21'sd205887;

	localparam logic [14:0] THR_RESET = 15'd16351;

	localparam logic signed [22:0] LIM_PI      = 23'sd25736;
	localparam logic signed [22:0] LIM_HALF_PI = 23'sd12868;
	localparam logic signed [22:0] LIM_TWO_PI  = 23'sd51472;

	typedef enum logic [1:0] {
		CASE_GEN   = 2'd0,
		CASE_NORTH = 2'd1,
		CASE_SOUTH = 2'd2
	} case_t;

	// operands that ride along the square root stages
	typedef struct packed {
		logic signed [AW-1:0] roll_y;
		logic signed [AW-1:0] roll_x;
		logic signed [AW-1:0] pitch_y;
		logic signed [AW-1:0] yaw_y;
		logic signed [AW-1:0] yaw_x;
		case_t                kind;
	} carry_t;

	function automatic logic signed [ZW-1:0] atan_lut(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:       r = 21'sd51472;
			1:       r = 21'sd30386;
			2:       r = 21'sd16055;
			3:       r = 21'sd8150;
			4:       r = 21'sd4091;
			5:       r = 21'sd2047;
			6:       r = 21'sd1024;
			7:       r = 21'sd512;
			8:       r = 21'sd256;
			9:       r = 21'sd128;
			10:      r = 21'sd64;
			11:      r = 21'sd32;
			12:      r = 21'sd16;
			13:      r = 21'sd8;
			14:      r = 21'sd4;
			15:      r = 21'sd2;
			16:      r = 21'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/quaternion_to_euler.sv
// quaternion to roll / pitch / yaw converter. one quaternion beat (x, y, z, w in signed
// Q1.15) enters per clock and one angle beat leaves for each; the pipeline takes a
// new beat every cycle and the whole pipeline holds while a result waits on m_tready.
// most of its depth is the 31 stages of the bit-per-stage square root (cos of pitch)
// followed by the 17 stages of the three parallel unrolled cordic lanes. angles come
// out in signed radians, 13 fraction bits: roll Q3.13 within +-pi, pitch Q2.13 within
// +-pi/2, yaw Q4.13 within +-pi (general) or +-2pi (near gimbal lock). when x*y + z*w
// lies strictly beyond +-singular_threshold (unsigned Q0.15, reset 0.499) the north /
// south pole formula is used: yaw = +-2*atan2(x, w), pitch = +-pi/2, roll = 0, and
// m_tuser reports which formula was applied. the user must write the threshold register
// through cfg_* only while the block is idle; this is not enforced. cfg_ready is always 1.
module quaternion_to_euler
	import qte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data,   // singular_threshold

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // quat_x, quat_y, quat_z, quat_w

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // roll_angle[15:0], pitch_angle[14:0], yaw_angle[16:0]
	output logic [1:0]  m_tuser     // case_code
);

	// one enable for the whole pipeline: it moves unless the output beat is stuck
	logic adv;
	logic out_vld_q;

	assign adv       = !out_vld_q || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	// threshold register
	logic [14:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// stage 1: all component products
	logic signed [15:0] qx, qy, qz, qw;
	assign qx = s_tdata[15:0];
	assign qy = s_tdata[31:16];
	assign qz = s_tdata[47:32];
	assign qw = s_tdata[63:48];

	logic               vld_s1;
	logic signed [31:0] p_xx_s1, p_yy_s1, p_zz_s1, p_xy_s1, p_wz_s1;
	logic signed [31:0] p_wx_s1, p_yz_s1, p_wy_s1, p_zx_s1;
	logic signed [15:0] x_s1, w_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_xx_s1 <= qx * qx;
			p_yy_s1 <= qy * qy;
			p_zz_s1 <= qz * qz;
			p_xy_s1 <= qx * qy;
			p_wz_s1 <= qw * qz;
			p_wx_s1 <= qw * qx;
			p_yz_s1 <= qy * qz;
			p_wy_s1 <= qw * qy;
			p_zx_s1 <= qz * qx;
			x_s1    <= qx;
			w_s1    <= qw;
		end
	end

	// stage 2: sums, singularity test and the saturated asin argument
	logic signed [AW-1:0] rn_c, rd_c, sraw_c, yn_c, yd_c, s_c;
	logic signed [32:0]   test_c;

	always_comb begin
		test_c = 33'(p_xy_s1) + 33'(p_wz_s1);
		rn_c   = (AW'(p_wx_s1) + AW'(p_yz_s1)) <<< 1;
		rd_c   = ONE_Q30 - ((AW'(p_xx_s1) + AW'(p_yy_s1)) <<< 1);
		sraw_c = (AW'(p_wy_s1) - AW'(p_zx_s1)) <<< 1;
		yn_c   = (AW'(p_wz_s1) + AW'(p_xy_s1)) <<< 1;
		yd_c   = ONE_Q30 - ((AW'(p_yy_s1) + AW'(p_zz_s1)) <<< 1);
		if (sraw_c > SAT_POS) begin
			s_c = SAT_POS;
		end else if (sraw_c < SAT_NEG) begin
			s_c = SAT_NEG;
		end else begin
			s_c = sraw_c;
		end
	end

	logic                 vld_s2;
	logic signed [32:0]   test_s2;
	logic signed [AW-1:0] rn_s2, rd_s2, yn_s2, yd_s2;
	logic signed [SW-1:0] s_s2;
	logic signed [15:0]   x_s2, w_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			test_s2 <= test_c;
			rn_s2   <= rn_c;
			rd_s2   <= rd_c;
			yn_s2   <= yn_c;
			yd_s2   <= yd_c;
			s_s2    <= s_c[SW-1:0];
			x_s2    <= x_s1;
			w_s2    <= w_s1;
		end
	end

	// stage 3: threshold compare, yaw operand select, square of the asin argument
	logic signed [32:0] thr_c;
	logic signed [61:0] ssq_c;
	case_t              kind_c;
	carry_t             car_c;

	always_comb begin
		thr_c = $signed({3'b000, thr_q, 15'b0});
		ssq_c = s_s2 * s_s2;
		if (test_s2 > thr_c) begin
			kind_c = CASE_NORTH;
		end else if (test_s2 < -thr_c) begin
			kind_c = CASE_SOUTH;
		end else begin
			kind_c = CASE_GEN;
		end
		car_c.roll_y  = rn_s2;
		car_c.roll_x  = rd_s2;
		car_c.pitch_y = AW'(s_s2);
		car_c.kind    = kind_c;
		if (kind_c == CASE_GEN) begin
			car_c.yaw_y = yn_s2;
			car_c.yaw_x = yd_s2;
		end else begin
			car_c.yaw_y = AW'(x_s2);
			car_c.yaw_x = AW'(w_s2);
		end
	end

	logic          vld_s3;
	logic [60:0]   ssq_s3;
	carry_t        car_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ssq_s3 <= ssq_c[60:0];
			car_s3 <= car_c;
		end
	end

	// stage 4: radicand 1 - s^2 in Q2.60, enters the root pipeline at index 0
	logic [RW-1:0] sq_rem_s [NSQ+1];
	logic [RW-1:0] sq_res_s [NSQ+1];
	carry_t        sq_car_s [NSQ+1];
	logic          sq_vld_s [NSQ+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rem_s[0] <= ONE_Q60 - RW'(ssq_s3);
			sq_res_s[0] <= '0;
			sq_car_s[0] <= car_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			sq_vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s1      <= s_tvalid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			sq_vld_s[0] <= vld_s3;
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NSQ - 1 - k));
		logic [RW-1:0] trial;

		assign trial = sq_res_s[k] + BIT;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (sq_rem_s[k] >= trial) begin
					sq_rem_s[k+1] <= sq_rem_s[k] - trial;
					sq_res_s[k+1] <= (sq_res_s[k] >> 1) + BIT;
				end else begin
					sq_rem_s[k+1] <= sq_rem_s[k];
					sq_res_s[k+1] <= sq_res_s[k] >> 1;
				end
				sq_car_s[k+1] <= sq_car_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end
	end

	// cordic lanes: 0 roll, 1 pitch, 2 yaw
	logic signed [CW-1:0] cx_s   [3][NCOR+1];
	logic signed [CW-1:0] cy_s   [3][NCOR+1];
	logic signed [ZW-1:0] cz_s   [3][NCOR+1];
	logic                 zr_s   [3][NCOR+1];
	case_t                cor_kind_s [NCOR+1];
	logic                 cor_vld_s  [NCOR+1];

	logic signed [AW-1:0] lane_y [3];
	logic signed [AW-1:0] lane_x [3];

	always_comb begin
		lane_y[0] = sq_car_s[NSQ].roll_y;
		lane_x[0] = sq_car_s[NSQ].roll_x;
		lane_y[1] = sq_car_s[NSQ].pitch_y;
		lane_x[1] = AW'(sq_res_s[NSQ][SW-1:0]);
		lane_y[2] = sq_car_s[NSQ].yaw_y;
		lane_x[2] = sq_car_s[NSQ].yaw_x;
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic signed [CW-1:0] px, py;

		assign px = CW'(lane_x[l]) <<< 16;
		assign py = CW'(lane_y[l]) <<< 16;

		// turn left half plane vectors by pi so the iterations converge
		always_ff @(posedge clk) begin
			if (adv) begin
				zr_s[l][0] <= (lane_x[l] == '0) && (lane_y[l] == '0);
				if (px < 0) begin
					cx_s[l][0] <= -px;
					cy_s[l][0] <= -py;
					cz_s[l][0] <= (py >= 0) ? ANG_PI : -ANG_PI;
				end else begin
					cx_s[l][0] <= px;
					cy_s[l][0] <= py;
					cz_s[l][0] <= '0;
				end
			end
		end

		for (genvar i = 0; i < NCOR; i++) begin : g_iter
			localparam logic signed [ZW-1:0] ATN = atan_lut(i);
			logic signed [CW-1:0] xs, ys;

			assign xs = cx_s[l][i] >>> i;
			assign ys = cy_s[l][i] >>> i;

			always_ff @(posedge clk) begin
				if (adv) begin
					if (cy_s[l][i] > 0) begin
						cx_s[l][i+1] <= cx_s[l][i] + ys;
						cy_s[l][i+1] <= cy_s[l][i] - xs;
						cz_s[l][i+1] <= cz_s[l][i] + ATN;
					end else begin
						cx_s[l][i+1] <= cx_s[l][i] - ys;
						cy_s[l][i+1] <= cy_s[l][i] + xs;
						cz_s[l][i+1] <= cz_s[l][i] - ATN;
					end
					zr_s[l][i+1] <= zr_s[l][i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cor_kind_s[0] <= sq_car_s[NSQ].kind;
			for (int i = 0; i < NCOR; i++) begin
				cor_kind_s[i+1] <= cor_kind_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NCOR; i++) begin
				cor_vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			cor_vld_s[0] <= sq_vld_s[NSQ];
			for (int i = 0; i < NCOR; i++) begin
				cor_vld_s[i+1] <= cor_vld_s[i];
			end
		end
	end

	// output stage: round to 13 fraction bits (roll Q3.13, pitch Q2.13, yaw Q4.13) and clamp
	function automatic logic signed [16:0] to_q13(input logic signed [22:0] v,
			input logic signed [22:0] lim);
		logic signed [22:0] r;
		r = (v + 23'sd4) >>> 3;
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r[16:0];
	endfunction

	logic signed [22:0] z_roll, z_pitch, z_yaw;
	logic signed [16:0] roll_c, pitch_c, yaw_c;
	case_t              kind_o;

	always_comb begin
		kind_o  = cor_kind_s[NCOR];
		z_roll  = zr_s[0][NCOR] ? '0 : 23'(cz_s[0][NCOR]);
		z_pitch = zr_s[1][NCOR] ? '0 : 23'(cz_s[1][NCOR]);
		z_yaw   = zr_s[2][NCOR] ? '0 : 23'(cz_s[2][NCOR]);
		case (kind_o)
			CASE_NORTH: begin
				roll_c  = '0;
				pitch_c = 17'(LIM_HALF_PI);
				yaw_c   = to_q13(z_yaw <<< 1, LIM_TWO_PI);
			end
			CASE_SOUTH: begin
				roll_c  = '0;
				pitch_c = -17'(LIM_HALF_PI);
				yaw_c   = to_q13(-(z_yaw <<< 1), LIM_TWO_PI);
			end
			default: begin
				roll_c  = to_q13(z_roll, LIM_PI);
				pitch_c = to_q13(z_pitch, LIM_HALF_PI);
				yaw_c   = to_q13(z_yaw, LIM_PI);
			end
		endcase
	end

	logic [15:0] roll_q;
	logic [14:0] pitch_q;
	logic [16:0] yaw_q;
	case_t       kind_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_q  <= roll_c[15:0];
			pitch_q <= pitch_c[14:0];
			yaw_q   <= yaw_c;
			kind_q  <= kind_o;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= cor_vld_s[NCOR];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {yaw_q, pitch_q, roll_q};
	assign m_tuser  = kind_q;

endmodule
